>>> rtl/kds_pkg.sv
// Shared types, constants and helper functions of the kick drum synthesizer.
package kds_pkg;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_FREQ  = 2'd0;
  localparam logic [1:0] REG_DECAY = 2'd1;
  localparam logic [1:0] REG_DROP  = 2'd2;
  localparam logic [1:0] REG_RATE  = 2'd3;

  // MIDI message types (upper nibble of the status byte)
  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;

  localparam int KEY_COUNT = 128;
  localparam int KEY_W     = $clog2(KEY_COUNT);

  // Cap on intermediate oscillator terms and on the step size
  localparam logic [40:0] TERM_CAP = 41'h100_0000_0000;
  localparam logic [29:0] K_MAX    = 30'h2000_0000;

  // Tick sequencer steps
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_K,
    ST_D2,
    ST_DC,
    ST_P2,
    ST_DAMP,
    ST_P3H,
    ST_P3L,
    ST_P3END,
    ST_CUBH,
    ST_CUBL,
    ST_CUBEND,
    ST_ACC,
    ST_AK,
    ST_SPD,
    ST_SK,
    ST_POS
  } state_t;

  // Note tracker state seen by the oscillator core
  typedef struct packed {
    logic [7:0] last_key;
    logic [6:0] last_velocity;
    logic       strike_pending;
  } notes_t;

  // 2^(r/12) in unsigned Q1.30
  function automatic logic [30:0] semitone(input logic [3:0] r);
    logic [30:0] v;
    case (r)
      4'd0:    v = 31'd1073741824;
      4'd1:    v = 31'd1137589835;
      4'd2:    v = 31'd1205234447;
      4'd3:    v = 31'd1276901416;
      4'd4:    v = 31'd1352829926;
      4'd5:    v = 31'd1433273379;
      4'd6:    v = 31'd1518500249;
      4'd7:    v = 31'd1608794973;
      4'd8:    v = 31'd1704458901;
      4'd9:    v = 31'd1805811302;
      4'd10:   v = 31'd1913190429;
      4'd11:   v = 31'd2026954652;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // Saturate a wide signed value to Q4.28
  function automatic logic signed [31:0] sat_q28(input logic signed [43:0] x);
    logic signed [31:0] r;
    if (x > 44'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -44'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Magnitude of a Q4.28 value
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    logic [31:0] r;
    r = x[31] ? 32'(-x) : 32'(x);
    return r;
  endfunction

endpackage

>>> rtl/kick_drum_oscillator_synth.sv
// Top level: config registers, tick sequencer and oscillator datapath.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  item in   | item_valid / item_stall    | op, status_byte, data_one, data_two
//  sample out| sample_valid / sample_stall| sample
//  config    | APB psel/penable/pready    | paddr, pwdata, prdata
//
// A MIDI item is taken without stalling the input and yields no sample.
// A tick item stalls the input while the sequencer steps through its states on the
// one shared 32x32 multiplier, so no new item is taken until its sample is in the
// output register. The sequencer issues at most one product per step and splits
// wide terms into partial products.
// A finished sample waits in the output register; the next item is taken
// meanwhile, and the last step holds only while that register is still full.
// Reset is synchronous and clears the sequencer, held keys and oscillator state.
module kick_drum_oscillator_synth (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        op,
  input  logic [7:0]  status_byte,
  input  logic [6:0]  data_one,
  input  logic [6:0]  data_two,
  output logic        sample_valid,
  input  logic        sample_stall,
  output logic signed [23:0] sample,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  kds_pkg::state_t state, state_next;
  kds_pkg::notes_t notes;

  logic [6:0]  freq_setting, decay_setting, drop_setting;
  logic [23:0] rate_scale;

  logic item_accept, tick_start, msg_accept, out_free;

  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [4:0]  oct;
  logic [3:0]  rem;
  logic [8:0]  idx;
  logic [16:0] oct_mul;
  logic [4:0]  oct_calc;
  logic [8:0]  rem_wide;

  logic [29:0] k;
  logic [13:0] d2;
  logic [14:0] dc;
  logic [34:0] p2;
  logic [35:0] damp;
  logic [33:0] hi_acc;
  logic [40:0] p3;
  logic [40:0] cub;
  logic signed [31:0] position, speed, accel;

  logic [31:0] ap, as_spd, aacc;
  logic [5:0]  sh;
  logic [63:0] k_shift;
  logic [29:0] k_val;
  logic [67:0] mac_sum;
  logic [40:0] p3_val, cub_val;
  logic [60:0] cub_t;
  logic signed [43:0] pos_e, spd_e, cub_e, damp_e, acc_w, r_e, vel_e, s_w, pos_w;
  logic signed [31:0] speed_val, pos_val;
  logic [31:0] apos;
  logic [28:0] apos_sh;
  logic signed [23:0] smp_val;

  assign pready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_setting  <= 7'd64;
      decay_setting <= 7'd64;
      drop_setting  <= 7'd64;
      rate_scale    <= 24'd966296;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        kds_pkg::REG_FREQ:  freq_setting  <= pwdata[6:0];
        kds_pkg::REG_DECAY: decay_setting <= pwdata[6:0];
        kds_pkg::REG_DROP:  drop_setting  <= pwdata[6:0];
        kds_pkg::REG_RATE:  rate_scale    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    unique case (paddr[3:2])
      kds_pkg::REG_FREQ:  prdata = {25'd0, freq_setting};
      kds_pkg::REG_DECAY: prdata = {25'd0, decay_setting};
      kds_pkg::REG_DROP:  prdata = {25'd0, drop_setting};
      kds_pkg::REG_RATE:  prdata = {8'd0, rate_scale};
      default:            prdata = 32'd0;
    endcase
  end

  // Input handshake
  assign item_stall  = (state != kds_pkg::ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign tick_start  = item_accept && op;
  assign msg_accept  = item_accept && !op;
  assign out_free    = !sample_valid || !sample_stall;

  kds_notes u_notes (
    .clk          (clk),
    .rst          (rst),
    .msg_accept   (msg_accept),
    .status_byte  (status_byte),
    .data_one     (data_one),
    .data_two     (data_two),
    .strike_clear (state == kds_pkg::ST_SPD),
    .notes        (notes)
  );

  kds_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Split the pitch index into octave and semitone
  always_comb begin
    idx      = 9'(freq_setting) + {notes.last_key[7], notes.last_key} + 9'd10;
    oct_mul  = 17'(idx) * 17'd171;
    oct_calc = oct_mul[15:11];
    rem_wide = idx - 9'(oct_calc) * 9'd12;
  end

  // Sequencer and multiplier operand select
  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_a      = 32'd0;
    mul_b      = 32'd0;
    unique case (state)
      kds_pkg::ST_IDLE: begin
        if (tick_start) begin
          state_next = kds_pkg::ST_K;
        end
      end
      kds_pkg::ST_K: begin
        mul_en = 1'b1;
        mul_a  = {8'd0, rate_scale};
        mul_b  = {1'b0, kds_pkg::semitone(rem)};
        state_next = kds_pkg::ST_D2;
      end
      kds_pkg::ST_D2: begin
        mul_en = 1'b1;
        mul_a  = {25'd0, drop_setting};
        mul_b  = {25'd0, drop_setting};
        state_next = kds_pkg::ST_DC;
      end
      kds_pkg::ST_DC: begin
        mul_en = 1'b1;
        mul_a  = 32'(decay_setting) + 32'd1;
        mul_b  = 32'(decay_setting) + 32'd1;
        state_next = kds_pkg::ST_P2;
      end
      kds_pkg::ST_P2: begin
        mul_en = 1'b1;
        mul_a  = ap;
        mul_b  = ap;
        state_next = kds_pkg::ST_DAMP;
      end
      kds_pkg::ST_DAMP: begin
        mul_en = 1'b1;
        mul_a  = as_spd;
        mul_b  = {17'd0, dc};
        state_next = kds_pkg::ST_P3H;
      end
      kds_pkg::ST_P3H: begin
        mul_en = 1'b1;
        mul_a  = {29'd0, p2[34:32]};
        mul_b  = ap;
        state_next = kds_pkg::ST_P3L;
      end
      kds_pkg::ST_P3L: begin
        mul_en = 1'b1;
        mul_a  = p2[31:0];
        mul_b  = ap;
        state_next = kds_pkg::ST_P3END;
      end
      kds_pkg::ST_P3END: begin
        state_next = kds_pkg::ST_CUBH;
      end
      kds_pkg::ST_CUBH: begin
        mul_en = 1'b1;
        mul_a  = {23'd0, p3[40:32]};
        mul_b  = {18'd0, d2};
        state_next = kds_pkg::ST_CUBL;
      end
      kds_pkg::ST_CUBL: begin
        mul_en = 1'b1;
        mul_a  = p3[31:0];
        mul_b  = {18'd0, d2};
        state_next = kds_pkg::ST_CUBEND;
      end
      kds_pkg::ST_CUBEND: begin
        state_next = kds_pkg::ST_ACC;
      end
      kds_pkg::ST_ACC: begin
        state_next = kds_pkg::ST_AK;
      end
      kds_pkg::ST_AK: begin
        mul_en = 1'b1;
        mul_a  = aacc;
        mul_b  = {2'd0, k};
        state_next = kds_pkg::ST_SPD;
      end
      kds_pkg::ST_SPD: begin
        state_next = kds_pkg::ST_SK;
      end
      kds_pkg::ST_SK: begin
        mul_en = 1'b1;
        mul_a  = as_spd;
        mul_b  = {2'd0, k};
        state_next = kds_pkg::ST_POS;
      end
      kds_pkg::ST_POS: begin
        if (out_free) begin
          state_next = kds_pkg::ST_IDLE;
        end
      end
      default: state_next = kds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath arithmetic around the shared product
  always_comb begin
    ap      = kds_pkg::mag32(position);
    as_spd  = kds_pkg::mag32(speed);
    aacc    = kds_pkg::mag32(accel);
    sh      = 6'd38 - {1'b0, oct};
    k_shift = prod >> sh;
    k_val   = (k_shift > 64'(kds_pkg::K_MAX)) ? kds_pkg::K_MAX : k_shift[29:0];
    mac_sum = {2'd0, hi_acc, 32'd0} + {4'd0, prod};
    p3_val  = (mac_sum[67:64] != 4'd0) ? kds_pkg::TERM_CAP : {5'd0, mac_sum[63:28]};
    cub_t   = mac_sum[67:7];
    cub_val = (cub_t > 61'(kds_pkg::TERM_CAP)) ? kds_pkg::TERM_CAP : cub_t[40:0];

    pos_e  = {{12{position[31]}}, position};
    spd_e  = {{12{speed[31]}}, speed};
    cub_e  = {3'd0, cub};
    damp_e = {8'd0, damp};
    acc_w  = -pos_e - (position[31] ? -cub_e : cub_e) - (speed[31] ? -damp_e : damp_e);

    // acc*k and speed*k, truncated toward zero
    r_e   = {11'd0, prod[60:28]};
    vel_e = notes.strike_pending ? {16'd0, notes.last_velocity, 21'd0} : 44'sd0;
    s_w   = spd_e + (accel[31] ? -r_e : r_e) + vel_e;
    speed_val = kds_pkg::sat_q28(s_w);
    pos_w   = pos_e + (speed[31] ? -r_e : r_e);
    pos_val = kds_pkg::sat_q28(pos_w);

    // Sample: position/8 toward zero, clipped to Q1.23
    apos    = kds_pkg::mag32(pos_val);
    apos_sh = apos[31:3];
    if (pos_val[31]) begin
      smp_val = (apos_sh > 29'd8388608) ? -24'sd8388608 : 24'(-$signed({1'b0, apos_sh}));
    end else begin
      smp_val = (apos_sh > 29'd8388607) ? 24'sd8388607 : 24'(apos_sh);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      speed    <= '0;
    end else begin
      unique case (state)
        kds_pkg::ST_IDLE: begin
          if (tick_start) begin
            oct <= oct_calc;
            rem <= rem_wide[3:0];
          end
        end
        kds_pkg::ST_D2:     k      <= k_val;
        kds_pkg::ST_DC:     d2     <= prod[13:0];
        kds_pkg::ST_P2:     dc     <= prod[14:0];
        kds_pkg::ST_DAMP:   p2     <= prod[62:28];
        kds_pkg::ST_P3H:    damp   <= prod[45:10];
        kds_pkg::ST_P3L:    hi_acc <= prod[33:0];
        kds_pkg::ST_P3END:  p3     <= p3_val;
        kds_pkg::ST_CUBL:   hi_acc <= prod[33:0];
        kds_pkg::ST_CUBEND: cub    <= cub_val;
        kds_pkg::ST_ACC:    accel  <= kds_pkg::sat_q28(acc_w);
        kds_pkg::ST_SPD:    speed  <= speed_val;
        kds_pkg::ST_POS: begin
          if (out_free) begin
            position <= pos_val;
            sample   <= smp_val;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (state == kds_pkg::ST_POS && out_free) begin
      sample_valid <= 1'b1;
    end else if (!sample_stall) begin
      sample_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/kds_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
module kds_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  // Register the product; hold it while idle
  always_ff @(posedge clk) begin
    if (en) begin
      p <= 64'(a) * 64'(b);
    end
  end

endmodule

>>> rtl/kds_notes.sv
// MIDI note tracker: held keys, last key and velocity, strike request.
module kds_notes (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 msg_accept,
  input  logic [7:0]           status_byte,
  input  logic [6:0]           data_one,
  input  logic [6:0]           data_two,
  input  logic                 strike_clear,
  output kds_pkg::notes_t      notes
);

  logic [kds_pkg::KEY_COUNT-1:0] key_held;
  logic [7:0]                    last_key;
  logic [6:0]                    last_velocity;
  logic                          strike_pending;
  logic                          note_on;
  logic                          note_off;
  logic [kds_pkg::KEY_W-1:0]     key;

  // Decode the message
  always_comb begin
    key      = data_one;
    note_on  = (status_byte[7:4] == kds_pkg::MIDI_NOTE_ON) && (data_two != 7'd0);
    note_off = (status_byte[7:4] == kds_pkg::MIDI_NOTE_OFF) ||
               ((status_byte[7:4] == kds_pkg::MIDI_NOTE_ON) && (data_two == 7'd0));
  end

  // Track held keys and latch the newest strike
  always_ff @(posedge clk) begin
    if (rst) begin
      key_held       <= '0;
      last_key       <= 8'hFF;
      last_velocity  <= 7'd0;
      strike_pending <= 1'b0;
    end else begin
      if (msg_accept && note_on && !key_held[key]) begin
        key_held[key]  <= 1'b1;
        last_key       <= {1'b0, data_one};
        last_velocity  <= data_two;
        strike_pending <= 1'b1;
      end else begin
        if (msg_accept && note_off && key_held[key]) begin
          key_held[key] <= 1'b0;
        end
        if (strike_clear) begin
          strike_pending <= 1'b0;
        end
      end
    end
  end

  assign notes.last_key       = last_key;
  assign notes.last_velocity  = last_velocity;
  assign notes.strike_pending = strike_pending;

endmodule

>>> rtl/kds_check.sv
// Port-level checker for the kick drum synthesizer, bound to the top level.
module kds_check (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        op,
  input logic        sample_valid,
  input logic        sample_stall,
  input logic signed [23:0] sample
);

  // Hold a stalled sample
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample))
    else $error("stalled sample dropped or changed");

  // Leave reset idle and empty
  a_reset: assert property (@(posedge clk)
    rst |=> !sample_valid && !item_stall)
    else $error("not idle after reset");

  // A MIDI item produces no sample
  a_midi_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !op && !sample_valid |=> !sample_valid)
    else $error("sample after MIDI item");

  // A tick keeps the input busy
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && op |=> item_stall)
    else $error("input not busy after tick");

endmodule

bind kick_drum_oscillator_synth kds_check u_kds_check (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .op           (op),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample)
);

>>> tb/kick_drum_oscillator_synth_tb.sv
// Testbench for the kick drum synthesizer: random MIDI and tick items checked against a predictor.
`timescale 1ns / 100ps

module kick_drum_oscillator_synth_tb;

  typedef struct {
    logic       op;
    logic [7:0] status;
    logic [6:0] key;
    logic [6:0] velo;
  } midi_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic op = 1'b0;
  logic [7:0] status_byte = 8'd0;
  logic [6:0] data_one = 7'd0;
  logic [6:0] data_two = 7'd0;
  logic sample_valid;
  logic sample_stall = 1'b0;
  logic signed [23:0] sample;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;

  kick_drum_oscillator_synth u_top (.*);

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [6:0] m_freq, m_decay, m_drop;
  logic [23:0] m_rate;
  bit m_held[128];
  logic [7:0] m_count;
  logic signed [8:0] m_last_key;
  logic [6:0] m_last_velo;
  bit m_strike;
  longint m_pos, m_spd;

  midi_item_t pending_items[$];
  logic signed [23:0] expected_samples[$];
  int mismatches = 0;
  int samples_seen = 0;
  int ticks_sent = 0;
  int notes_sent = 0;
  bit quiet = 1'b0;
  bit sender_hold = 1'b0;

  function automatic longint unsigned mul_cap(longint unsigned a, longint unsigned b, int s);
    longint unsigned r;
    if (a == 0 || b == 0) return 0;
    if (a > 64'hFFFF_FFFF_FFFF_FFFF / b) return 64'd1 << 40;
    r = (a * b) >> s;
    return r > (64'd1 << 40) ? (64'd1 << 40) : r;
  endfunction

  function automatic longint clamp_q28(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned absval(longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint scale_by_k(longint x, longint unsigned k);
    longint r;
    r = longint'((absval(x) * k) >> 28);
    return x < 0 ? -r : r;
  endfunction

  function automatic longint unsigned semitone_ratio(int r);
    case (r)
      0: return 1073741824;  1: return 1137589835;  2: return 1205234447;
      3: return 1276901416;  4: return 1352829926;  5: return 1433273379;
      6: return 1518500249;  7: return 1608794973;  8: return 1704458901;
      9: return 1805811302; 10: return 1913190429; default: return 2026954652;
    endcase
  endfunction

  // advance the predictor by one item; push a sample for ticks
  task automatic predict_item(midi_item_t it);
    int idx, oct;
    longint unsigned k, ap, d2, dc, p2, p3, prod;
    longint cub, damp, acc, s, smp;
    bit on, off;
    if (!it.op) begin
      on = (it.status[7:4] == kds_pkg::MIDI_NOTE_ON) && it.velo != 0;
      off = (it.status[7:4] == kds_pkg::MIDI_NOTE_OFF) ||
            (it.status[7:4] == kds_pkg::MIDI_NOTE_ON && it.velo == 0);
      if (on && !m_held[it.key]) begin
        m_held[it.key] = 1'b1;
        m_count = m_count + 8'd1;
        m_last_key = {2'b00, it.key};
        m_last_velo = it.velo;
        m_strike = 1'b1;
      end else if (off && m_held[it.key]) begin
        m_held[it.key] = 1'b0;
        m_count = m_count - 8'd1;
      end
      return;
    end
    idx = int'(m_freq) + int'(m_last_key) + 10;
    oct = idx / 12;
    prod = longint'(m_rate) * semitone_ratio(idx % 12);
    k = prod >> (38 - oct);
    if (k > (64'd1 << 29)) k = 64'd1 << 29;
    ap = absval(m_pos);
    d2 = longint'(m_drop) * longint'(m_drop);
    dc = (longint'(m_decay) + 1) * (longint'(m_decay) + 1);
    p2 = mul_cap(ap, ap, 28);
    p3 = mul_cap(p2, ap, 28);
    cub = longint'(mul_cap(p3, d2, 7));
    damp = longint'(mul_cap(absval(m_spd), dc, 10));
    acc = -m_pos;
    acc -= m_pos < 0 ? -cub : cub;
    acc -= m_spd < 0 ? -damp : damp;
    acc = clamp_q28(acc);
    s = m_spd + scale_by_k(acc, k);
    if (m_strike) begin
      s += longint'(m_last_velo) << 21;
      m_strike = 1'b0;
    end
    m_spd = clamp_q28(s);
    m_pos = clamp_q28(m_pos + scale_by_k(m_spd, k));
    smp = m_pos < 0 ? -longint'(absval(m_pos) >> 3) : longint'(absval(m_pos) >> 3);
    if (smp > 8388607) smp = 8388607;
    if (smp < -8388608) smp = -8388608;
    expected_samples.push_back(smp[23:0]);
  endtask

  // drive pending items; hold the payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!(item_valid && item_stall)) begin
      if (pending_items.size() > 0 && !sender_hold && (quiet || $urandom_range(99) >= 13)) begin
        midi_item_t it;
        it = pending_items.pop_front();
        predict_item(it);
        if (it.op) ticks_sent++; else notes_sent++;
        item_valid <= 1'b1;
        op <= it.op;
        status_byte <= it.status;
        data_one <= it.key;
        data_two <= it.velo;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // check samples against the predicted queue; stall at random
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) begin
      samples_seen++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %0d", sample);
      end else begin
        logic signed [23:0] want;
        want = expected_samples.pop_front();
        if (want !== sample) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: expected %0d actual %0d", want, sample);
        end
      end
    end
    sample_stall <= rst ? 1'b0 : (!quiet && $urandom_range(99) < 13);
  end

  // watchdog on cycles without any accepted item or sample
  int idle_run = 0;
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (sample_valid && !sample_stall)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run > 20000) begin
      $display("kick_drum_oscillator_synth verification failed");
      $finish;
    end
  end

  task automatic apb_write(logic [1:0] index, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {index, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (index)
      kds_pkg::REG_FREQ:  m_freq = value[6:0];
      kds_pkg::REG_DECAY: m_decay = value[6:0];
      kds_pkg::REG_DROP:  m_drop = value[6:0];
      default:            m_rate = value[23:0];
    endcase
  endtask

  // wait until every item is sent and every predicted sample is checked, then idle
  task automatic drain();
    while (pending_items.size() > 0 || item_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic midi_item_t mk(logic o, logic [7:0] st, logic [6:0] k, logic [6:0] v);
    midi_item_t it;
    it.op = o; it.status = st; it.key = k; it.velo = v;
    return it;
  endfunction

  // mostly ticks, note-ons and note-offs, with noise
  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      int r;
      r = $urandom_range(99);
      if (r < 55) pending_items.push_back(mk(1'b1, 8'd0, 7'd0, 7'd0));
      else if (r < 70)
        pending_items.push_back(mk(1'b0, {kds_pkg::MIDI_NOTE_ON, 4'($urandom)},
                                   7'($urandom), 7'($urandom_range(127, 1))));
      else if (r < 80)
        pending_items.push_back(mk(1'b0, {kds_pkg::MIDI_NOTE_OFF, 4'($urandom)},
                                   7'($urandom), 7'($urandom)));
      else if (r < 85)
        pending_items.push_back(mk(1'b0, {kds_pkg::MIDI_NOTE_ON, 4'($urandom)},
                                   7'($urandom), 7'd0));
      else
        pending_items.push_back(mk(1'($urandom), 8'($urandom), 7'($urandom), 7'($urandom)));
    end
  endtask

  initial begin
    m_freq = 7'd64; m_decay = 7'd64; m_drop = 7'd64; m_rate = 24'd966296;
    foreach (m_held[i]) m_held[i] = 1'b0;
    m_count = 8'd0; m_last_key = -9'sd1; m_last_velo = 7'd0; m_strike = 1'b0;
    m_pos = 0; m_spd = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: tick before any note, extremes, repeats, note off forms, ignored types
    pending_items.push_back(mk(1'b1, 8'd0, 7'd0, 7'd0));
    pending_items.push_back(mk(1'b0, 8'h9F, 7'd127, 7'd127));
    pending_items.push_back(mk(1'b0, 8'h90, 7'd127, 7'd5));
    pending_items.push_back(mk(1'b1, 8'hFF, 7'd127, 7'd127));
    pending_items.push_back(mk(1'b0, 8'h80, 7'd3, 7'd0));
    pending_items.push_back(mk(1'b0, 8'h90, 7'd127, 7'd0));
    pending_items.push_back(mk(1'b0, 8'h90, 7'd0, 7'd1));
    pending_items.push_back(mk(1'b0, 8'hA0, 7'd9, 7'd9));
    pending_items.push_back(mk(1'b0, 8'hF5, 7'd9, 7'd9));
    pending_items.push_back(mk(1'b0, 8'h00, 7'd9, 7'd9));
    for (int i = 0; i < 6; i++) pending_items.push_back(mk(1'b1, 8'd0, 7'd0, 7'd0));
    pending_items.push_back(mk(1'b0, 8'h8A, 7'd0, 7'd127));
    drain();

    // extreme settings, then zero rate
    apb_write(kds_pkg::REG_FREQ, 32'd127); apb_write(kds_pkg::REG_DECAY, 32'd0);
    apb_write(kds_pkg::REG_DROP, 32'd127); apb_write(kds_pkg::REG_RATE, 32'hFFFFFF);
    queue_random(300);
    drain();
    apb_write(kds_pkg::REG_RATE, 32'd0); apb_write(kds_pkg::REG_FREQ, 32'd0);
    apb_write(kds_pkg::REG_DECAY, 32'd127); apb_write(kds_pkg::REG_DROP, 32'd0);
    queue_random(100);
    drain();

    // random settings with the sender held once until all samples are back
    for (int ph = 0; ph < 4; ph++) begin
      apb_write(kds_pkg::REG_FREQ, $urandom_range(127));
      apb_write(kds_pkg::REG_DECAY, $urandom_range(127));
      apb_write(kds_pkg::REG_DROP, $urandom_range(127));
      apb_write(kds_pkg::REG_RATE, ph == 0 ? 32'd966296 : $urandom_range(24'hFFFFFF));
      quiet = (ph == 2);
      queue_random(300);
      if (ph == 1) begin
        while (pending_items.size() > 150) @(posedge clk);
        sender_hold = 1'b1;
        while (item_valid || expected_samples.size() > 0) @(posedge clk);
        sender_hold = 1'b0;
      end
      drain();
    end
    quiet = 1'b0;

    $display("sent %0d ticks and %0d MIDI messages, checked %0d samples",
             ticks_sent, notes_sent, samples_seen);
    if (mismatches == 0) $display("kick_drum_oscillator_synth verification clean");
    else $display("kick_drum_oscillator_synth verification failed");
    $finish;
  end

endmodule

>>> kick_drum_oscillator_synth.f
rtl/kds_pkg.sv
rtl/kds_mul.sv
rtl/kds_notes.sv
rtl/kick_drum_oscillator_synth.sv
rtl/kds_check.sv
tb/kick_drum_oscillator_synth_tb.sv
